@@ design/clt_pkg.sv @@
// clt_pkg: shared types and constants of the counting lock table
// depends on nothing; every other file of the block imports it
`default_nettype none

package clt_pkg;

    localparam int NUM_RESOURCES_DEF = 16;
    localparam int MAX_HOLDERS_DEF   = 8;
    localparam int ID_BITS_DEF       = 8;

    localparam int RES_IDX_W  = 4;
    localparam int REQ_ID_W   = 8;
    localparam int STATUS_W   = 3;
    localparam int HOLDERS_W  = 4;
    localparam int IN_USE_W   = 5;
    localparam int MUTEX_W    = 16;
    localparam int CAP_W      = 64;
    localparam int CAP_NIB_W  = 4;
    localparam int PDATA_W    = 64;
    localparam int PADDR_W    = 5;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED     = 3'd0,
        STAT_WAIT        = 3'd1,
        STAT_ALREADY     = 3'd2,
        STAT_RELEASED    = 3'd3,
        STAT_NOT_HOLDER  = 3'd4,
        STAT_NO_RESOURCE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_IN_USE   = 2'd0,
        REG_MUTEX    = 2'd1,
        REG_CAPACITY = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_SHIFT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [IN_USE_W-1:0] in_use;
        logic [MUTEX_W-1:0]  mutex_mask;
        logic [CAP_W-1:0]    capacity;
    } cfg_t;

    typedef struct packed {
        logic    load;
        logic    start;
        logic    advance;
        logic    wr_grant;
        logic    wr_shift;
        logic    dec_count;
        logic    finish;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        logic known;
        logic release_req;
        logic mutex;
        logic n_zero;
        logic n_one;
        logic has_room;
        logic match;
        logic more;
    } sts_t;

endpackage

`default_nettype wire

@@ design/clt_ifs.sv @@
// clt_req_if and clt_rsp_if: valid/ready channels of the lock table
// depends on clt_pkg for the field widths
`default_nettype none

interface clt_req_if
    import clt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [RES_IDX_W-1:0] resource_index;
    logic [REQ_ID_W-1:0]  requester_id;

    modport source (output valid, action, resource_index, requester_id, input ready);
    modport sink   (input valid, action, resource_index, requester_id, output ready);
endinterface

interface clt_rsp_if
    import clt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [HOLDERS_W-1:0] holders_now;

    modport source (output valid, status, holders_now, input ready);
    modport sink   (input valid, status, holders_now, output ready);
endinterface

`default_nettype wire

@@ design/clt_regs.sv @@
// clt_regs: apb configuration registers of the lock table
// depends on clt_pkg for cfg_t and the register index codes
`default_nettype none

module clt_regs
    import clt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_idx_t idx;
    logic     wr_en;

    assign idx    = cfg_idx_t'(paddr[PADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_IN_USE:   cfg_reg.in_use     <= pwdata[IN_USE_W-1:0];
                REG_MUTEX:    cfg_reg.mutex_mask <= pwdata[MUTEX_W-1:0];
                REG_CAPACITY: cfg_reg.capacity   <= pwdata[CAP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_IN_USE:   prdata = PDATA_W'(cfg_reg.in_use);
            REG_MUTEX:    prdata = PDATA_W'(cfg_reg.mutex_mask);
            REG_CAPACITY: prdata = PDATA_W'(cfg_reg.capacity);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/clt_ctrl.sv @@
// clt_ctrl: sequencer of the lock table, drives the datapath by commands
// depends on clt_pkg for state_t, cmd_t, sts_t and status_t
`default_nettype none

module clt_ctrl
    import clt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = STAT_GRANTED;
        req_ready      = 1'b0;
        rsp_valid      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.known)
                begin
                    cmd.finish     = 1'b1;
                    cmd.res_status = STAT_NO_RESOURCE;
                end
                else if (sts.release_req && sts.mutex && !sts.n_one)
                begin
                    cmd.finish     = 1'b1;
                    cmd.res_status = STAT_NOT_HOLDER;
                end
                else if (sts.n_zero)
                begin
                    cmd.finish = 1'b1;
                    if (sts.release_req)
                    begin
                        cmd.res_status = STAT_NOT_HOLDER;
                    end
                    else if (sts.has_room)
                    begin
                        cmd.wr_grant   = 1'b1;
                        cmd.res_status = STAT_GRANTED;
                    end
                    else
                    begin
                        cmd.res_status = STAT_WAIT;
                    end
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SEARCH;
                end
                if (cmd.finish)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SEARCH:
            begin
                if (sts.match)
                begin
                    if (!sts.release_req)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.res_status = STAT_ALREADY;
                    end
                    else if (sts.more)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_SHIFT;
                    end
                    else
                    begin
                        cmd.dec_count  = 1'b1;
                        cmd.finish     = 1'b1;
                        cmd.res_status = STAT_RELEASED;
                    end
                end
                else if (sts.more)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    if (sts.release_req)
                    begin
                        cmd.res_status = STAT_NOT_HOLDER;
                    end
                    else if (sts.has_room)
                    begin
                        cmd.wr_grant   = 1'b1;
                        cmd.res_status = STAT_GRANTED;
                    end
                    else
                    begin
                        cmd.res_status = STAT_WAIT;
                    end
                end
                if (cmd.finish)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SHIFT:
            begin
                cmd.wr_shift = 1'b1;
                if (sts.more)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.dec_count  = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.res_status = STAT_RELEASED;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/clt_dp.sv @@
// clt_dp: request registers, holder counts, holder id memory and result word
// depends on clt_pkg for cfg_t, cmd_t, sts_t and the field widths
`default_nettype none

module clt_dp
    import clt_pkg::*;
#(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int MAX_HOLDERS   = MAX_HOLDERS_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire cmd_t                 cmd,
    input  wire logic                 action,
    input  wire logic [RES_IDX_W-1:0] resource_index,
    input  wire logic [REQ_ID_W-1:0]  requester_id,
    output sts_t                      sts,
    output logic [STATUS_W-1:0]       status,
    output logic [HOLDERS_W-1:0]      holders_now
);

    localparam int Depth = NUM_RESOURCES * MAX_HOLDERS;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int ResW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int SlotW = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;

    logic                 action_reg;
    logic [RES_IDX_W-1:0] res_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [SlotW-1:0]     idx_reg;
    logic [ID_BITS-1:0]   rdata_reg;
    logic [HOLDERS_W-1:0] count_reg [NUM_RESOURCES];
    status_t              status_reg;
    logic [HOLDERS_W-1:0] holders_reg;
    logic [ID_BITS-1:0]   mem [Depth];

    logic                 known;
    logic [ResW-1:0]      r_idx;
    logic [HOLDERS_W-1:0] n;
    logic [CAP_NIB_W-1:0] cap_raw;
    logic [HOLDERS_W-1:0] cap;
    logic [HOLDERS_W-1:0] idx_ext;
    logic [AddrW-1:0]     base;
    logic [SlotW-1:0]     rd_slot;
    logic [AddrW-1:0]     rd_addr;
    logic [AddrW-1:0]     wr_addr;
    logic [ID_BITS-1:0]   wr_data;
    logic                 wr_en;

    assign known = ({1'b0, res_reg} < cfg.in_use)
                && ({1'b0, res_reg} < (RES_IDX_W + 1)'(NUM_RESOURCES));
    assign r_idx = known ? res_reg[ResW-1:0] : '0;
    assign n     = count_reg[r_idx];

    assign cap_raw = cfg.capacity[{res_reg, 2'b00} +: CAP_NIB_W];
    always_comb
    begin
        if (cfg.mutex_mask[res_reg])
        begin
            cap = HOLDERS_W'(1);
        end
        else if (HOLDERS_W'(cap_raw) > HOLDERS_W'(MAX_HOLDERS))
        begin
            cap = HOLDERS_W'(MAX_HOLDERS);
        end
        else
        begin
            cap = HOLDERS_W'(cap_raw);
        end
    end

    assign idx_ext = HOLDERS_W'(idx_reg);

    assign sts.known       = known;
    assign sts.release_req = (action_reg == ACT_RELEASE);
    assign sts.mutex       = cfg.mutex_mask[res_reg];
    assign sts.n_zero      = (n == '0);
    assign sts.n_one       = (n == HOLDERS_W'(1));
    assign sts.has_room    = (n < cap) && (n < HOLDERS_W'(MAX_HOLDERS));
    assign sts.match       = (rdata_reg == id_reg);
    assign sts.more        = ((idx_ext + HOLDERS_W'(1)) < n);

    // slot addressing within the row of one resource
    assign base    = AddrW'(r_idx) * AddrW'(MAX_HOLDERS);
    assign rd_slot = cmd.start ? '0 : SlotW'(idx_ext + HOLDERS_W'(1));
    assign rd_addr = base + AddrW'(rd_slot);
    assign wr_addr = cmd.wr_grant ? base + AddrW'(n) : base + AddrW'(idx_reg) - AddrW'(1);
    assign wr_data = cmd.wr_grant ? id_reg : rdata_reg;
    assign wr_en   = cmd.wr_grant || cmd.wr_shift;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.start || cmd.advance)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            res_reg    <= resource_index;
            id_reg     <= ID_BITS'(requester_id);
        end
        if (cmd.start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= SlotW'(idx_ext + HOLDERS_W'(1));
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.res_status;
            if (cmd.res_status == STAT_NO_RESOURCE)
            begin
                holders_reg <= '0;
            end
            else if (cmd.wr_grant)
            begin
                holders_reg <= n + HOLDERS_W'(1);
            end
            else if (cmd.dec_count)
            begin
                holders_reg <= n - HOLDERS_W'(1);
            end
            else
            begin
                holders_reg <= n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (cmd.wr_grant)
        begin
            count_reg[r_idx] <= n + HOLDERS_W'(1);
        end
        else if (cmd.dec_count)
        begin
            count_reg[r_idx] <= n - HOLDERS_W'(1);
        end
    end

    assign status      = status_reg;
    assign holders_now = holders_reg;

endmodule

`default_nettype wire

@@ design/counting_lock_table.sv @@
// counting_lock_table: table of mutexes and counting semaphores with holder lists
// usage
//   req channel carries one request word: action (acquire or release),
//   resource_index and requester_id; rsp channel returns one word per
//   request: status and holders_now, the holder count after the request
//   configuration goes through the apb port: resources_in_use at 0x00,
//   mutex_mask at 0x08, capacity_table at 0x10; the user must see that they
//   are written only while idle, as the block itself has no check for it
//   one request is worked at a time; req.ready is high only when idle
//   the check state settles an unknown resource, an empty list or a refused
//   mutex release; else the holder search reads the list entry by entry and
//   a release that removes entry p of n shifts the later entries down; search
//   and shift together walk a list of at most MAX_HOLDERS entries through
//   the single read port of the holder id memory, one entry a cycle; the
//   response word is then held in a register while rsp.ready is low, and the
//   block returns to idle when it is taken
//   reset clears the state, configuration and all holder counts; the holder
//   id memory needs no clearing since only entries below a count are read
// depends on clt_pkg, clt_ifs, clt_regs, clt_ctrl and clt_dp
`default_nettype none

module counting_lock_table
    import clt_pkg::*;
#(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int MAX_HOLDERS   = MAX_HOLDERS_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    clt_req_if.sink                 req,
    clt_rsp_if.source               rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic req_ready;
    logic rsp_valid;

    clt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    clt_dp #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .MAX_HOLDERS   (MAX_HOLDERS),
        .ID_BITS       (ID_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .action         (req.action),
        .resource_index (req.resource_index),
        .requester_id   (req.requester_id),
        .sts            (sts),
        .status         (rsp.status),
        .holders_now    (rsp.holders_now)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

@@ dv/counting_lock_table_tb.sv @@
`timescale 1ns / 100ps
// counting_lock_table_tb: self-checking bench for the counting lock table
// drives request words and apb writes, predicts each answer word and checks it
// depends on clt_pkg, clt_ifs and counting_lock_table

module counting_lock_table_tb
    import clt_pkg::*;
;

    typedef struct packed {
        status_t              status;
        logic [HOLDERS_W-1:0] holders;
    } lock_answer_t;

    class lock_ledger;
        logic [IN_USE_W-1:0] in_use;
        logic [MUTEX_W-1:0]  mutex_mask;
        logic [CAP_W-1:0]    capacity;
        logic [REQ_ID_W-1:0] holder_id [NUM_RESOURCES_DEF][MAX_HOLDERS_DEF];
        int                  holder_cnt [NUM_RESOURCES_DEF];
        lock_answer_t        awaited [$];
        int                  mismatches;
        int                  answers;
        int                  seen [6];

        function new();
            in_use = '0;
            mutex_mask = '0;
            capacity = '0;
            mismatches = 0;
            answers = 0;
            foreach (holder_cnt[r])
                holder_cnt[r] = 0;
            foreach (seen[s])
                seen[s] = 0;
        endfunction

        function void set_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
            case (addr)
                {REG_IN_USE, 3'b000}:   in_use = value[IN_USE_W-1:0];
                {REG_MUTEX, 3'b000}:    mutex_mask = value[MUTEX_W-1:0];
                {REG_CAPACITY, 3'b000}: capacity = value[CAP_W-1:0];
                default: ;
            endcase
        endfunction

        function int slots_of(int r);
            int cap;
            if (mutex_mask[r])
                return 1;
            cap = int'(capacity[CAP_NIB_W*r +: CAP_NIB_W]);
            return (cap > MAX_HOLDERS_DEF) ? MAX_HOLDERS_DEF : cap;
        endfunction

        function int holder_pos(int r, logic [REQ_ID_W-1:0] who);
            for (int i = 0; i < holder_cnt[r]; i++)
                if (holder_id[r][i] == who)
                    return i;
            return -1;
        endfunction

        function void note_request(logic act, logic [RES_IDX_W-1:0] idx,
                                   logic [REQ_ID_W-1:0] who);
            lock_answer_t want;
            int r;
            int n;
            int pos;
            r = int'(idx);
            if (r >= int'(in_use))
            begin
                want.status = STAT_NO_RESOURCE;
                want.holders = '0;
            end
            else
            begin
                n = holder_cnt[r];
                pos = holder_pos(r, who);
                if (act == ACT_ACQUIRE)
                begin
                    if (pos >= 0)
                        want.status = STAT_ALREADY;
                    else if (n < slots_of(r) && n < MAX_HOLDERS_DEF)
                    begin
                        holder_id[r][n] = who;
                        holder_cnt[r] = n + 1;
                        want.status = STAT_GRANTED;
                    end
                    else
                        want.status = STAT_WAIT;
                end
                else if (mutex_mask[r])
                begin
                    if (n == 1 && holder_id[r][0] == who)
                    begin
                        holder_cnt[r] = 0;
                        want.status = STAT_RELEASED;
                    end
                    else
                        want.status = STAT_NOT_HOLDER;
                end
                else if (pos >= 0)
                begin
                    for (int j = pos; j + 1 < n; j++)
                        holder_id[r][j] = holder_id[r][j+1];
                    holder_cnt[r] = n - 1;
                    want.status = STAT_RELEASED;
                end
                else
                    want.status = STAT_NOT_HOLDER;
                want.holders = HOLDERS_W'(holder_cnt[r]);
            end
            awaited.push_back(want);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [HOLDERS_W-1:0] hn);
            lock_answer_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $error("answer word with none awaited: status %0d holders_now %0d", st, hn);
                return;
            end
            want = awaited.pop_front();
            answers++;
            seen[want.status]++;
            if (st !== want.status)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $error("status: expected %0d got %0d", want.status, st);
            end
            if (hn !== want.holders)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $error("holders_now: expected %0d got %0d", want.holders, hn);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 300;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 5'h18;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 send_idle_pct = 38;
    int                 recv_idle_pct = 51;
    int                 cycles = 0;
    int                 settings = 0;
    lock_ledger         ledger;

    clt_req_if req_ch();
    clt_rsp_if rsp_ch();

    counting_lock_table DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            ledger.check_result(rsp_ch.status, rsp_ch.holders_now);
        rsp_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic offer_request(input logic act, input logic [RES_IDX_W-1:0] idx,
                                 input logic [REQ_ID_W-1:0] who);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid          <= 1'b1;
        req_ch.action         <= act;
        req_ch.resource_index <= idx;
        req_ch.requester_id   <= who;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        ledger.note_request(act, idx, who);
    endtask

    // hold off until every answer word is back and the block is idle
    task automatic settle_table();
        req_ch.valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        ledger.set_register(addr, value);
    endtask

    task automatic program_table(input logic [IN_USE_W-1:0] in_use_set,
                                 input logic [MUTEX_W-1:0] mask_set,
                                 input logic [CAP_W-1:0] cap_set);
        write_register({REG_IN_USE, 3'b000}, PDATA_W'(in_use_set));
        write_register({REG_MUTEX, 3'b000}, PDATA_W'(mask_set));
        write_register({REG_CAPACITY, 3'b000}, PDATA_W'(cap_set));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int                   live;
        logic                 act;
        logic [RES_IDX_W-1:0] idx;
        logic [REQ_ID_W-1:0]  who;
        logic [REQ_ID_W-1:0]  id_pool [6];
        logic [IN_USE_W-1:0]  in_use_set;
        logic [MUTEX_W-1:0]   mask_set;
        logic [CAP_W-1:0]     cap_set;

        ledger = new();
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.action         <= ACT_ACQUIRE;
        req_ch.resource_index <= '0;
        req_ch.requester_id   <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing configured yet
        offer_request(ACT_ACQUIRE, 4'd0, 8'h00);
        offer_request(ACT_RELEASE, 4'd15, 8'hFF);
        settle_table();

        // r0 mutex, r1 two slots, r2 none, r3 saturated, the rest eight
        write_register(ADDR_UNMAPPED, '1);
        program_table(5'd16, 16'h0001, 64'h8888_8888_8888_F020);
        offer_request(ACT_ACQUIRE, 4'd0, 8'h00);
        offer_request(ACT_ACQUIRE, 4'd0, 8'h00);
        offer_request(ACT_ACQUIRE, 4'd0, 8'hFF);
        offer_request(ACT_RELEASE, 4'd0, 8'hFF);
        offer_request(ACT_RELEASE, 4'd0, 8'h00);
        offer_request(ACT_ACQUIRE, 4'd1, 8'hA5);
        offer_request(ACT_ACQUIRE, 4'd1, 8'h5A);
        offer_request(ACT_ACQUIRE, 4'd1, 8'h11);
        offer_request(ACT_RELEASE, 4'd1, 8'hA5);
        offer_request(ACT_RELEASE, 4'd1, 8'hA5);
        offer_request(ACT_ACQUIRE, 4'd2, 8'h01);
        for (int k = 0; k < 9; k++)
            offer_request(ACT_ACQUIRE, 4'd3, 8'h80 + 8'(k));
        offer_request(ACT_RELEASE, 4'd3, 8'h80);
        offer_request(ACT_ACQUIRE, 4'd15, 8'hFF);
        settle_table();

        // r3 is marked mutex with many holders but falls outside the resources in use, r1 keeps a holder above capacity
        program_table(5'd3, 16'h0008, 64'h8888_8888_8888_F000);
        offer_request(ACT_RELEASE, 4'd3, 8'h81);
        offer_request(ACT_ACQUIRE, 4'd1, 8'h22);
        offer_request(ACT_RELEASE, 4'd1, 8'h5A);
        offer_request(ACT_ACQUIRE, 4'd15, 8'h33);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle_table();
            send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 51 : 0;
            recv_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 38 : 0;
            case (ph)
                0:
                begin
                    in_use_set = 5'd16;
                    mask_set = '0;
                    cap_set = {$urandom, $urandom};
                end
                1:
                begin
                    in_use_set = 5'd31;
                    mask_set = '1;
                    cap_set = '0;
                end
                2:
                begin
                    in_use_set = IN_USE_W'($urandom_range(15, 1));
                    mask_set = MUTEX_W'($urandom_range(65535));
                    cap_set = '1;
                end
                3:
                begin
                    in_use_set = 5'd16;
                    mask_set = MUTEX_W'($urandom_range(65535));
                    cap_set = {$urandom, $urandom};
                end
                4:
                begin
                    in_use_set = 5'd8;
                    mask_set = 16'h00FF;
                    cap_set = {$urandom, $urandom};
                end
                default:
                begin
                    in_use_set = IN_USE_W'($urandom_range(16, 1));
                    mask_set = '0;
                    cap_set = {$urandom, $urandom};
                end
            endcase
            program_table(in_use_set, mask_set, cap_set);
            live = (int'(in_use_set) > NUM_RESOURCES_DEF) ? NUM_RESOURCES_DEF
                                                          : int'(in_use_set);
            foreach (id_pool[p])
                id_pool[p] = REQ_ID_W'($urandom_range(255));
            for (int w = 0; w < PHASE_WORDS; w++)
            begin
                act = ($urandom_range(99) < 55) ? ACT_ACQUIRE : ACT_RELEASE;
                if (live > 0 && $urandom_range(99) < 85)
                    idx = RES_IDX_W'($urandom_range(live - 1));
                else
                    idx = RES_IDX_W'($urandom_range(15));
                if ($urandom_range(99) < 75)
                    who = id_pool[$urandom_range(5)];
                else
                    who = REQ_ID_W'($urandom_range(255));
                offer_request(act, idx, who);
            end
        end

        settle_table();
        repeat (20) @(posedge clk);
        $display("%0d request words answered over %0d register settings",
                 ledger.answers, settings);
        $display("granted %0d, wait %0d, already %0d, released %0d, not holder %0d, unknown %0d",
                 ledger.seen[STAT_GRANTED], ledger.seen[STAT_WAIT], ledger.seen[STAT_ALREADY],
                 ledger.seen[STAT_RELEASED], ledger.seen[STAT_NOT_HOLDER],
                 ledger.seen[STAT_NO_RESOURCE]);
        if (ledger.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
design/clt_pkg.sv
design/clt_ifs.sv
design/clt_regs.sv
design/clt_ctrl.sv
design/clt_dp.sv
design/counting_lock_table.sv
dv/counting_lock_table_tb.sv
